// ----- sv/rss_pkg.sv -----
package rss_pkg;

    localparam int COORD_W   = 24;
    localparam int ANG_W     = 16;
    localparam int DIST_W    = 24;
    localparam int HIT_IDX_W = 5;
    localparam int HIT_CAP   = 32;
    localparam int HIT_CNT_W = 6;
    localparam int HIT_AW    = 5;

    // CORDIC direction vector, scale 2^16
    localparam int DIR_W       = 19;
    localparam int CORDIC_ITER = 15;
    localparam int CORDIC_X0   = 39797;
    localparam int Z_W         = 18;

    localparam int DIFF_W  = COORD_W + 1;
    localparam int MUL_W   = 26;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int DEN_W   = 45;
    localparam int CROSS_W = 51;
    localparam int NUM_W   = CROSS_W + 16;
    localparam int T_W     = 41;
    localparam int T_LO_W  = 21;
    localparam int REM_W   = DEN_W + T_W - 1;
    localparam int ACC_W   = 62;
    localparam int HX_W    = 48;

    localparam int HALF_Q8    = 128;
    localparam int ROUND_Q16  = 32768;
    localparam logic [ANG_W-1:0] HALF_TURN = 16'h8000;
    localparam logic [DIST_W-1:0] DIST_MAX = 24'hFFFFFF;
    localparam logic [ANG_W-1:0] FOV_RESET = 16'd16384;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_CAST   = 2'd2;

    typedef struct packed {
        logic [1:0]                command;
        logic signed [COORD_W-1:0] seg_start_x;
        logic signed [COORD_W-1:0] seg_start_y;
        logic signed [COORD_W-1:0] seg_end_x;
        logic signed [COORD_W-1:0] seg_end_y;
        logic [ANG_W-1:0]          ray_angle;
        logic signed [COORD_W-1:0] player_x;
        logic signed [COORD_W-1:0] player_y;
        logic [ANG_W-1:0]          player_heading;
    } in_item_t;

    typedef struct packed {
        logic                      hit_valid;
        logic [HIT_IDX_W-1:0]      segment_index;
        logic signed [COORD_W-1:0] hit_x;
        logic signed [COORD_W-1:0] hit_y;
        logic [DIST_W-1:0]         hit_distance;
        logic                      last;
    } out_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [COORD_W-1:0] ex;
        logic signed [COORD_W-1:0] ey;
    } seg_entry_t;

    typedef struct packed {
        logic [HIT_IDX_W-1:0]      idx;
        logic signed [COORD_W-1:0] hx;
        logic signed [COORD_W-1:0] hy;
        logic [DIST_W-1:0]         range_q8;
    } hit_entry_t;

    function automatic logic [13:0] atan_step(input logic [3:0] i);
        logic [13:0] r;
        case (i)
            4'd0:    r = 14'd8192;
            4'd1:    r = 14'd4836;
            4'd2:    r = 14'd2555;
            4'd3:    r = 14'd1297;
            4'd4:    r = 14'd651;
            4'd5:    r = 14'd326;
            4'd6:    r = 14'd163;
            4'd7:    r = 14'd81;
            4'd8:    r = 14'd41;
            4'd9:    r = 14'd20;
            4'd10:   r = 14'd10;
            4'd11:   r = 14'd5;
            4'd12:   r = 14'd3;
            4'd13:   r = 14'd1;
            4'd14:   r = 14'd1;
            default: r = 14'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- sv/rss_cordic.sv -----
module rss_cordic
    import rss_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [ANG_W-1:0]        angle,
    output logic                    done,
    output logic signed [DIR_W-1:0] dx,
    output logic signed [DIR_W-1:0] dy
);

    logic                    busy_reg;
    logic                    done_reg;
    logic [3:0]              iter_reg;
    logic                    flip_reg;
    logic signed [DIR_W-1:0] x_reg;
    logic signed [DIR_W-1:0] y_reg;
    logic signed [Z_W-1:0]   z_reg;

    logic signed [Z_W-1:0]   z_init;
    logic                    flip_init;
    logic signed [DIR_W-1:0] xs;
    logic signed [DIR_W-1:0] ys;
    logic signed [Z_W-1:0]   step;

    always_comb
    begin
        z_init    = Z_W'($signed(angle));
        flip_init = 1'b0;
        if (z_init > Z_W'(16384))
        begin
            z_init    = z_init - Z_W'(32768);
            flip_init = 1'b1;
        end
        else if (z_init < -Z_W'(16384))
        begin
            z_init    = z_init + Z_W'(32768);
            flip_init = 1'b1;
        end
        xs   = x_reg >>> iter_reg;
        ys   = y_reg >>> iter_reg;
        step = Z_W'(atan_step(iter_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                iter_reg <= '0;
            end
            else if (busy_reg)
            begin
                iter_reg <= iter_reg + 4'd1;
                if (iter_reg == 4'(CORDIC_ITER - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= DIR_W'(CORDIC_X0);
            y_reg    <= '0;
            z_reg    <= z_init;
            flip_reg <= flip_init;
        end
        else if (busy_reg)
        begin
            if (z_reg >= 0)
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - step;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + step;
            end
        end
    end

    assign done = done_reg;
    assign dx   = flip_reg ? -x_reg : x_reg;
    assign dy   = flip_reg ? -y_reg : y_reg;

endmodule

// ----- sv/rss_div.sv -----
module rss_div
    import rss_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [T_W-1:0]   quo
);

    logic             busy_reg;
    logic             done_reg;
    logic [5:0]       bit_reg;
    logic [REM_W-1:0] rem_reg;
    logic [REM_W-1:0] ds_reg;
    logic [T_W-1:0]   quo_reg;

    logic             sat;
    logic             fits;

    // A quotient of 2^40 or more saturates at once.
    assign sat  = REM_W'(num) >= {den, {(T_W-1){1'b0}}};
    assign fits = rem_reg >= ds_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            bit_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                bit_reg  <= 6'(T_W - 2);
                busy_reg <= !sat;
                done_reg <= sat;
            end
            else if (busy_reg)
            begin
                bit_reg <= bit_reg - 6'd1;
                if (bit_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= REM_W'(num);
            ds_reg  <= REM_W'({den, {(T_W-2){1'b0}}});
            quo_reg <= sat ? {1'b1, {(T_W-1){1'b0}}} : '0;
        end
        else if (busy_reg)
        begin
            ds_reg <= ds_reg >> 1;
            if (fits)
            begin
                rem_reg          <= rem_reg - ds_reg;
                quo_reg[bit_reg] <= 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ----- sv/ray_segment_hit_sorter_top.sv -----
// Ray/segment hit sorter. Append items fill a table of up to MAX_SEGMENTS wall
// segments; a clear item empties it. A cast item turns the ray angle into a
// direction with a 15-step CORDIC, then walks the table one segment at a time
// through one shared 26x26 multiplier and a restoring divider that makes one
// quotient bit per cycle. Each kept hit is insertion-sorted into a 32-entry
// hit memory, one entry moved per read and compare step, and the hits then
// leave nearest first, one item per free output slot; a cast with no hit
// gives one invalid item. Most of a cast's time goes to the divider and to
// the insertion sweep. The input stalls for the whole cast.
module ray_segment_hit_sorter_top
    import rss_pkg::*;
#(
    parameter int MAX_SEGMENTS = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [ANG_W-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_item_t         in_item,
    output logic             out_valid,
    input  logic             out_stall,
    output out_item_t        out_item
);

    localparam int SIW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int SCW = $clog2(MAX_SEGMENTS + 1);

    typedef enum logic [21:0] {
        S_IDLE    = 22'h000001,
        S_DIR     = 22'h000002,
        S_SEG_RD  = 22'h000004,
        S_SEG_LD  = 22'h000008,
        S_MA      = 22'h000010,
        S_MB      = 22'h000020,
        S_MC      = 22'h000040,
        S_MD      = 22'h000080,
        S_ME      = 22'h000100,
        S_DIV_GO  = 22'h000200,
        S_DIV     = 22'h000400,
        S_H1      = 22'h000800,
        S_H2      = 22'h001000,
        S_H3      = 22'h002000,
        S_H4      = 22'h004000,
        S_H5      = 22'h008000,
        S_H6      = 22'h010000,
        S_TEST    = 22'h020000,
        S_INS_RD  = 22'h040000,
        S_INS_CMP = 22'h080000,
        S_EMIT_RD = 22'h100000,
        S_EMIT_LD = 22'h200000
    } state_t;

    state_t state_reg, state_next;

    logic [ANG_W-1:0]     fov_reg;
    logic [SCW-1:0]       seg_count_reg;
    logic [SCW-1:0]       seg_k_reg;
    logic [HIT_CNT_W-1:0] hit_count_reg;
    logic [HIT_CNT_W-1:0] ins_j_reg;
    logic [HIT_AW-1:0]    emit_k_reg;
    logic                 out_valid_reg;
    out_item_t            out_reg;

    seg_entry_t seg_mem [MAX_SEGMENTS];
    seg_entry_t seg_q;
    hit_entry_t hit_mem [HIT_CAP];
    hit_entry_t hit_q;

    logic [ANG_W-1:0]          ang_reg;
    logic [ANG_W-1:0]          heading_reg;
    logic signed [COORD_W-1:0] px_reg;
    logic signed [COORD_W-1:0] py_reg;
    logic signed [DIR_W-1:0]   dx_reg;
    logic signed [DIR_W-1:0]   dy_reg;
    logic signed [DIFF_W-1:0]  ex_reg, ey_reg, wx_reg, wy_reg;
    logic signed [COORD_W-1:0] mnx_reg, mxx_reg, mny_reg, mxy_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [DEN_W-1:0]   den_reg;
    logic signed [CROSS_W-1:0] m_reg;
    logic                      neg_reg;
    logic                      zero_reg;
    logic signed [DIR_W-1:0]   dxe_reg, dye_reg;
    logic [T_W-1:0]            t_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [HX_W-1:0]    hx_reg, hy_reg;

    logic                     in_accept;
    logic                     out_free;
    logic                     cordic_start, cordic_done;
    logic signed [DIR_W-1:0]  cordic_dx, cordic_dy;
    logic                     div_done;
    logic [T_W-1:0]           div_quo;
    logic [NUM_W-1:0]         div_num;
    logic [DEN_W-1:0]         div_den;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic [MUL_W-1:0]         t_lo, t_hi;
    logic signed [ACC_W-1:0]  acc_round;
    logic signed [HX_W-1:0]   hxy_next;
    logic                     box_ok, ang_ok, keep;
    logic [ANG_W-1:0]         bearing, diff;
    logic [ANG_W:0]           absd;
    hit_entry_t               new_hit;
    logic                     greater;
    logic                     ins_done;
    logic                     seg_done;
    logic                     hit_we;
    logic [HIT_AW-1:0]        hit_wa;
    hit_entry_t               hit_wd;
    logic                     hit_re;
    logic [HIT_AW-1:0]        hit_ra;
    logic                     emit_last;
    logic [CROSS_W-1:0]       m_mag;

    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [HX_W-1:0] v);
        logic signed [HX_W-1:0] hi;
        logic signed [HX_W-1:0] lo;
        hi = HX_W'({1'b0, {(COORD_W-1){1'b1}}});
        lo = -hi - HX_W'(1);
        if (v > hi)
            return COORD_W'(hi);
        else if (v < lo)
            return COORD_W'(lo);
        return COORD_W'(v);
    endfunction

    rss_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .angle (in_item.ray_angle),
        .done  (cordic_done),
        .dx    (cordic_dx),
        .dy    (cordic_dy)
    );

    assign m_mag   = m_reg[CROSS_W-1] ? CROSS_W'(-m_reg) : CROSS_W'(m_reg);
    assign div_num = {m_mag, 16'b0};
    assign div_den = den_reg[DEN_W-1] ? DEN_W'(-den_reg) : DEN_W'(den_reg);

    rss_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_DIV_GO),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign in_stall     = (state_reg != S_IDLE);
    assign in_accept    = in_valid && !in_stall;
    assign cordic_start = in_accept && (in_item.command == CMD_CAST);
    assign cfg_ready    = 1'b1;
    assign out_free     = !out_valid_reg || !out_stall;
    assign out_valid    = out_valid_reg;
    assign out_item     = out_reg;

    // Shared multiplier operand selection.
    assign t_lo = MUL_W'(t_reg[T_LO_W-1:0]);
    assign t_hi = MUL_W'(t_reg[T_W-1:T_LO_W]);

    always_comb
    begin
        mul_a = MUL_W'(dx_reg);
        mul_b = MUL_W'(ey_reg);
        case (state_reg)
            S_MB:
            begin
                mul_a = MUL_W'(dy_reg);
                mul_b = MUL_W'(ex_reg);
            end
            S_MC:
            begin
                mul_a = MUL_W'(wx_reg);
                mul_b = MUL_W'(ey_reg);
            end
            S_MD:
            begin
                mul_a = MUL_W'(wy_reg);
                mul_b = MUL_W'(ex_reg);
            end
            S_H1:
            begin
                mul_a = MUL_W'(dxe_reg);
                mul_b = $signed(t_lo);
            end
            S_H2:
            begin
                mul_a = MUL_W'(dxe_reg);
                mul_b = $signed(t_hi);
            end
            S_H3:
            begin
                mul_a = MUL_W'(dye_reg);
                mul_b = $signed(t_lo);
            end
            S_H4:
            begin
                mul_a = MUL_W'(dye_reg);
                mul_b = $signed(t_hi);
            end
            default:
            begin
                mul_a = MUL_W'(dx_reg);
                mul_b = MUL_W'(ey_reg);
            end
        endcase
    end

    assign acc_round = acc_reg + ACC_W'(ROUND_Q16);

    always_comb
    begin
        hxy_next = HX_W'(acc_round >>> 16);
        if (state_reg == S_H4)
            hxy_next = hxy_next + HX_W'(px_reg);
        else
            hxy_next = hxy_next + HX_W'(py_reg);
    end

    // Keep test: widened box on both axes, then bearing against the view cone.
    always_comb
    begin
        box_ok = (hx_reg > HX_W'(mnx_reg) - HX_W'(HALF_Q8))
              && (hx_reg < HX_W'(mxx_reg) + HX_W'(HALF_Q8))
              && (hy_reg > HX_W'(mny_reg) - HX_W'(HALF_Q8))
              && (hy_reg < HX_W'(mxy_reg) + HX_W'(HALF_Q8));
        if (zero_reg)
            bearing = '0;
        else
            bearing = ang_reg + (neg_reg ? HALF_TURN : '0);
        diff   = bearing - heading_reg;
        absd   = diff[ANG_W-1] ? (17'h10000 - {1'b0, diff}) : {1'b0, diff};
        ang_ok = {absd, 1'b0} <= {2'b00, fov_reg};
        keep   = box_ok && ang_ok;
    end

    always_comb
    begin
        new_hit.idx      = HIT_IDX_W'({{HIT_IDX_W{1'b0}}, seg_k_reg});
        new_hit.hx       = sat_coord(hx_reg);
        new_hit.hy       = sat_coord(hy_reg);
        new_hit.range_q8 = (t_reg > T_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(t_reg);
    end

    assign greater  = hit_q.range_q8 > new_hit.range_q8;
    assign ins_done = ((state_reg == S_INS_RD) && (ins_j_reg == '0))
                   || ((state_reg == S_INS_CMP) && !greater);
    assign seg_done = ((state_reg == S_MD) && (den_reg == '0))
                   || ((state_reg == S_TEST) && !keep)
                   || ins_done;

    // Hit memory ports: one write and one read per cycle.
    always_comb
    begin
        hit_we = 1'b0;
        hit_wa = HIT_AW'(ins_j_reg);
        hit_wd = new_hit;
        if ((state_reg == S_INS_RD) && (ins_j_reg == '0))
            hit_we = 1'b1;
        else if ((state_reg == S_INS_CMP) && (ins_j_reg < HIT_CNT_W'(HIT_CAP)))
        begin
            hit_we = 1'b1;
            hit_wd = greater ? hit_q : new_hit;
        end
        hit_re = (state_reg == S_INS_RD) || (state_reg == S_EMIT_RD);
        hit_ra = (state_reg == S_EMIT_RD) ? emit_k_reg : HIT_AW'(ins_j_reg - HIT_CNT_W'(1));
    end

    assign emit_last = (hit_count_reg == '0)
                    || ((HIT_CNT_W'(emit_k_reg) + HIT_CNT_W'(1)) == hit_count_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:    if (cordic_start) state_next = S_DIR;
            S_DIR:     if (cordic_done) state_next = S_SEG_RD;
            S_SEG_RD:  state_next = (seg_k_reg == seg_count_reg) ? S_EMIT_RD : S_SEG_LD;
            S_SEG_LD:  state_next = S_MA;
            S_MA:      state_next = S_MB;
            S_MB:      state_next = S_MC;
            S_MC:      state_next = S_MD;
            S_MD:      state_next = (den_reg == '0) ? S_SEG_RD : S_ME;
            S_ME:      state_next = S_DIV_GO;
            S_DIV_GO:  state_next = S_DIV;
            S_DIV:     if (div_done) state_next = S_H1;
            S_H1:      state_next = S_H2;
            S_H2:      state_next = S_H3;
            S_H3:      state_next = S_H4;
            S_H4:      state_next = S_H5;
            S_H5:      state_next = S_H6;
            S_H6:      state_next = S_TEST;
            S_TEST:    state_next = keep ? S_INS_RD : S_SEG_RD;
            S_INS_RD:  state_next = (ins_j_reg == '0) ? S_SEG_RD : S_INS_CMP;
            S_INS_CMP: state_next = greater ? S_INS_RD : S_SEG_RD;
            S_EMIT_RD: state_next = S_EMIT_LD;
            S_EMIT_LD: if (out_free) state_next = emit_last ? S_IDLE : S_EMIT_RD;
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fov_reg       <= FOV_RESET;
            seg_count_reg <= '0;
            seg_k_reg     <= '0;
            hit_count_reg <= '0;
            ins_j_reg     <= '0;
            emit_k_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                fov_reg <= cfg_data;
            if (in_accept)
            begin
                if (in_item.command == CMD_CLEAR)
                    seg_count_reg <= '0;
                else if ((in_item.command == CMD_APPEND)
                         && (seg_count_reg < SCW'(MAX_SEGMENTS)))
                    seg_count_reg <= seg_count_reg + SCW'(1);
            end
            if (cordic_start)
            begin
                seg_k_reg     <= '0;
                hit_count_reg <= '0;
            end
            if (seg_done)
                seg_k_reg <= seg_k_reg + SCW'(1);
            if ((state_reg == S_TEST) && keep)
                ins_j_reg <= hit_count_reg;
            if ((state_reg == S_INS_CMP) && greater)
                ins_j_reg <= ins_j_reg - HIT_CNT_W'(1);
            if (ins_done && (hit_count_reg < HIT_CNT_W'(HIT_CAP)))
                hit_count_reg <= hit_count_reg + HIT_CNT_W'(1);
            if ((state_reg == S_SEG_RD) && (seg_k_reg == seg_count_reg))
                emit_k_reg <= '0;
            if ((state_reg == S_EMIT_LD) && out_free)
            begin
                out_valid_reg <= 1'b1;
                if (!emit_last)
                    emit_k_reg <= emit_k_reg + HIT_AW'(1);
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && (in_item.command == CMD_APPEND)
            && (seg_count_reg < SCW'(MAX_SEGMENTS)))
        begin
            seg_mem[SIW'(seg_count_reg)] <= '{sx: in_item.seg_start_x,
                                              sy: in_item.seg_start_y,
                                              ex: in_item.seg_end_x,
                                              ey: in_item.seg_end_y};
        end
        if (state_reg == S_SEG_RD && seg_k_reg != seg_count_reg)
            seg_q <= seg_mem[SIW'(seg_k_reg)];
        if (hit_we)
            hit_mem[hit_wa] <= hit_wd;
        if (hit_re)
            hit_q <= hit_mem[hit_ra];
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(mul_a * mul_b);
        if (cordic_start)
        begin
            ang_reg     <= in_item.ray_angle;
            heading_reg <= in_item.player_heading;
            px_reg      <= in_item.player_x;
            py_reg      <= in_item.player_y;
        end
        if (cordic_done)
        begin
            dx_reg <= cordic_dx;
            dy_reg <= cordic_dy;
        end
        case (state_reg)
            S_SEG_LD:
            begin
                ex_reg  <= DIFF_W'(seg_q.ex) - DIFF_W'(seg_q.sx);
                ey_reg  <= DIFF_W'(seg_q.ey) - DIFF_W'(seg_q.sy);
                wx_reg  <= DIFF_W'(seg_q.sx) - DIFF_W'(px_reg);
                wy_reg  <= DIFF_W'(seg_q.sy) - DIFF_W'(py_reg);
                mnx_reg <= (seg_q.sx < seg_q.ex) ? seg_q.sx : seg_q.ex;
                mxx_reg <= (seg_q.sx < seg_q.ex) ? seg_q.ex : seg_q.sx;
                mny_reg <= (seg_q.sy < seg_q.ey) ? seg_q.sy : seg_q.ey;
                mxy_reg <= (seg_q.sy < seg_q.ey) ? seg_q.ey : seg_q.sy;
            end
            S_MB: den_reg <= DEN_W'(prod_reg);
            S_MC: den_reg <= den_reg - DEN_W'(prod_reg);
            S_MD: m_reg <= CROSS_W'(prod_reg);
            S_ME: m_reg <= m_reg - CROSS_W'(prod_reg);
            S_DIV_GO:
            begin
                // The ray is scaled by the sign of t so the products stay unsigned in t.
                neg_reg  <= m_reg[CROSS_W-1] ^ den_reg[DEN_W-1];
                zero_reg <= (m_reg == '0);
                dxe_reg  <= (m_reg[CROSS_W-1] ^ den_reg[DEN_W-1]) ? -dx_reg : dx_reg;
                dye_reg  <= (m_reg[CROSS_W-1] ^ den_reg[DEN_W-1]) ? -dy_reg : dy_reg;
            end
            S_DIV: if (div_done) t_reg <= div_quo;
            S_H2:  acc_reg <= ACC_W'(prod_reg);
            S_H3:  acc_reg <= acc_reg + (ACC_W'(prod_reg) <<< T_LO_W);
            S_H4:
            begin
                hx_reg  <= hxy_next;
                acc_reg <= ACC_W'(prod_reg);
            end
            S_H5:  acc_reg <= acc_reg + (ACC_W'(prod_reg) <<< T_LO_W);
            S_H6:  hy_reg <= hxy_next;
            S_EMIT_LD:
            begin
                if (out_free)
                begin
                    if (hit_count_reg == '0)
                    begin
                        out_reg <= '{hit_valid: 1'b0, segment_index: '0, hit_x: '0,
                                     hit_y: '0, hit_distance: '0, last: 1'b1};
                    end
                    else
                    begin
                        out_reg.hit_valid     <= 1'b1;
                        out_reg.segment_index <= hit_q.idx;
                        out_reg.hit_x         <= hit_q.hx;
                        out_reg.hit_y         <= hit_q.hy;
                        out_reg.hit_distance  <= hit_q.range_q8;
                        out_reg.last          <= emit_last;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    a_hit_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        hit_count_reg <= HIT_CNT_W'(HIT_CAP))
        else $error("hit count beyond capacity");

    a_seg_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        seg_count_reg <= SCW'(MAX_SEGMENTS))
        else $error("segment count beyond table depth");

    a_no_hit_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.hit_valid |-> out_item.last && (out_item.hit_distance == '0))
        else $error("invalid item must be the last and carry zeros");

    a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside its state");

endmodule

// ----- verif/tb.sv -----
module tb;
    import rss_pkg::*;

    localparam int TABLE_DEPTH = 32;
    localparam longint T_SAT = 64'd1 << 40;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct {
        logic signed [63:0] sx;
        logic signed [63:0] sy;
        logic signed [63:0] ex;
        logic signed [63:0] ey;
    } wall_t;

    logic      clk;
    logic      rst_n;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [ANG_W-1:0] cfg_data;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_item;

    in_item_t  pending_items[$];
    out_item_t expected_hits[$];
    wall_t     walls[TABLE_DEPTH];
    int        wall_count;
    logic [ANG_W-1:0] view_angle;
    int        send_idle_pct;
    int        recv_idle_pct;
    int        errors;
    int        cycles;
    int        casts_sent;

    ray_segment_hit_sorter_top DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
    );

    always #2 clk = ~clk;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    task automatic ray_direction(input logic [15:0] ang, output longint dx, output longint dy);
        int     z;
        longint x;
        longint y;
        longint xs;
        longint ys;
        bit     flip;
        int     steps[15];
        steps = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1};
        z = int'(ang);
        x = 39797;
        y = 0;
        flip = 0;
        if (z >= 32768) z -= 65536;
        if (z > 16384) begin z -= 32768; flip = 1; end
        else if (z < -16384) begin z += 32768; flip = 1; end
        for (int i = 0; i < 15; i++)
        begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (z >= 0) begin x -= ys; y += xs; z -= steps[i]; end
            else begin x += ys; y -= xs; z += steps[i]; end
        end
        dx = flip ? -x : x;
        dy = flip ? -y : y;
    endtask

    function automatic longint clamp_coord(longint v);
        if (v > 64'sd8388607) return 64'sd8388607;
        if (v < -64'sd8388608) return -64'sd8388608;
        return v;
    endfunction

    // Works out the sorted hits of one cast against the current wall table.
    task automatic predict_cast(input in_item_t it);
        out_item_t found[$];
        out_item_t r;
        longint dx, dy, px, py, ex, ey, wx, wy, den, ts, hx, hy;
        longint mnx, mxx, mny, mxy;
        logic signed [127:0] num;
        logic [127:0] q;
        logic [63:0] t;
        logic [15:0] bearing, diff, absd;
        int pos;
        ray_direction(it.ray_angle, dx, dy);
        px = longint'(it.player_x);
        py = longint'(it.player_y);
        for (int k = 0; k < wall_count; k++)
        begin
            ex = walls[k].ex - walls[k].sx;
            ey = walls[k].ey - walls[k].sy;
            wx = walls[k].sx - px;
            wy = walls[k].sy - py;
            den = dx * ey - dy * ex;
            if (den == 0) continue;
            num = 128'(wx) * 128'(ey) - 128'(wy) * 128'(ex);
            q = ((num < 0 ? -num : num) << 16) / 128'(den < 0 ? -den : den);
            t = (q >= 128'(T_SAT)) ? 64'(T_SAT) : 64'(q);
            ts = ((num < 0) != (den < 0)) ? -longint'(t) : longint'(t);
            hx = px + floor_shift(dx * ts + 32768, 16);
            hy = py + floor_shift(dy * ts + 32768, 16);
            mnx = walls[k].sx < walls[k].ex ? walls[k].sx : walls[k].ex;
            mxx = walls[k].sx < walls[k].ex ? walls[k].ex : walls[k].sx;
            mny = walls[k].sy < walls[k].ey ? walls[k].sy : walls[k].ey;
            mxy = walls[k].sy < walls[k].ey ? walls[k].ey : walls[k].sy;
            if (!(hx - mnx > -HALF_Q8 && hx - mxx < HALF_Q8)) continue;
            if (!(hy - mny > -HALF_Q8 && hy - mxy < HALF_Q8)) continue;
            if (num == 0) bearing = '0;
            else bearing = it.ray_angle + (((num < 0) != (den < 0)) ? HALF_TURN : 16'd0);
            diff = bearing - it.player_heading;
            absd = diff >= HALF_TURN ? 16'(17'h10000 - diff) : diff;
            if (17'(absd) * 2 > 17'(view_angle)) continue;
            r.hit_valid = 1'b1;
            r.segment_index = k[4:0];
            r.hit_x = COORD_W'(clamp_coord(hx));
            r.hit_y = COORD_W'(clamp_coord(hy));
            r.hit_distance = (t > 64'(DIST_MAX)) ? DIST_MAX : t[23:0];
            r.last = 1'b0;
            pos = 0;
            while (pos < found.size() && found[pos].hit_distance <= r.hit_distance) pos++;
            if (pos < HIT_CAP)
            begin
                found.insert(pos, r);
                if (found.size() > HIT_CAP) void'(found.pop_back());
            end
        end
        if (found.size() == 0)
        begin
            r = '0;
            r.last = 1'b1;
            found.insert(0, r);
        end
        else found[found.size()-1].last = 1'b1;
        foreach (found[i]) expected_hits.insert(expected_hits.size(), found[i]);
    endtask

    task automatic apply_item(input in_item_t it);
        case (it.command)
            CMD_CLEAR: wall_count = 0;
            CMD_APPEND:
                if (wall_count < TABLE_DEPTH)
                begin
                    walls[wall_count].sx = 64'(it.seg_start_x);
                    walls[wall_count].sy = 64'(it.seg_start_y);
                    walls[wall_count].ex = 64'(it.seg_end_x);
                    walls[wall_count].ey = 64'(it.seg_end_y);
                    wall_count++;
                end
            CMD_CAST: predict_cast(it);
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // Driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_item <= '0;
        end
        else if (!(in_valid && in_stall))
        begin
            if (in_valid) apply_item(in_item);
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_item <= pending_items.pop_front();
                in_valid <= 1'b1;
            end
            else in_valid <= 1'b0;
        end
    end

    // Monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_hits.size() == 0) report_mismatch("unexpected item", 1, 0);
                else
                begin
                    out_item_t w;
                    w = expected_hits.pop_front();
                    if (out_item.hit_valid !== w.hit_valid)
                        report_mismatch("hit_valid", out_item.hit_valid, w.hit_valid);
                    if (out_item.segment_index !== w.segment_index)
                        report_mismatch("segment_index", out_item.segment_index, w.segment_index);
                    if (out_item.hit_x !== w.hit_x) report_mismatch("hit_x", out_item.hit_x, w.hit_x);
                    if (out_item.hit_y !== w.hit_y) report_mismatch("hit_y", out_item.hit_y, w.hit_y);
                    if (out_item.hit_distance !== w.hit_distance)
                        report_mismatch("hit_distance", out_item.hit_distance, w.hit_distance);
                    if (out_item.last !== w.last) report_mismatch("last", out_item.last, w.last);
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout");
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic signed [23:0] rand_coord();
        case ($urandom_range(4))
            0: return 24'sh7FFFFF;
            1: return -24'sh800000;
            2: return 24'($urandom);
            default: return 24'($signed($urandom_range(4096)) - 2048);
        endcase
    endfunction

    task automatic queue_seg(input logic signed [23:0] a, b, c, d);
        in_item_t it;
        it = in_item_t'($urandom);
        it.command = CMD_APPEND;
        it.seg_start_x = a; it.seg_start_y = b; it.seg_end_x = c; it.seg_end_y = d;
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic queue_cast(input logic [15:0] ang, input logic signed [23:0] x, y,
                              input logic [15:0] hd);
        in_item_t it;
        it = '0;
        it.seg_start_x = 24'($urandom);
        it.seg_end_y = 24'($urandom);
        it.command = CMD_CAST;
        it.ray_angle = ang; it.player_x = x; it.player_y = y; it.player_heading = hd;
        pending_items.insert(pending_items.size(), it);
        casts_sent++;
    endtask

    task automatic queue_clear(input logic [1:0] cmd);
        in_item_t it;
        it = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        it.command = cmd;
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || in_valid || expected_hits.size() > 0)
            @(posedge clk);
        // A clear or append can still be in flight after the last result.
        repeat (100) @(posedge clk);
    endtask

    task automatic write_view(input logic [15:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        view_angle = v;
    endtask

    task automatic random_scene(input int n);
        logic signed [23:0] cx, cy;
        logic [15:0] a;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(9))
                0: queue_clear(CMD_CLEAR);
                1: queue_clear(2'd3);
                2, 3, 4:
                begin
                    cx = 24'($signed($urandom_range(8192)) - 4096);
                    cy = 24'($signed($urandom_range(8192)) - 4096);
                    queue_seg(cx, cy, cx + 24'($signed($urandom_range(2048)) - 1024),
                              cy + 24'($signed($urandom_range(2048)) - 1024));
                end
                5: queue_seg(rand_coord(), rand_coord(), rand_coord(), rand_coord());
                default:
                begin
                    a = 16'($urandom);
                    if ($urandom_range(3) == 0)
                        queue_cast(a, rand_coord(), rand_coord(), 16'($urandom));
                    else
                        queue_cast(a, 24'($signed($urandom_range(2048)) - 1024),
                                   24'($signed($urandom_range(2048)) - 1024),
                                   a + 16'($signed($urandom_range(8192)) - 4096));
                end
            endcase
        end
    endtask

    initial
    begin
        clk = 0;
        rst_n = 0;
        cfg_valid = 0;
        cfg_data = '0;
        errors = 0;
        cycles = 0;
        casts_sent = 0;
        wall_count = 0;
        view_angle = FOV_RESET;
        send_idle_pct = 20;
        recv_idle_pct = 57;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: empty table, degenerate and parallel walls, vertical ray, extremes.
        queue_cast(16'd0, 24'sd0, 24'sd0, 16'd0);
        queue_seg(24'sd1280, -24'sd1280, 24'sd1280, 24'sd1280);
        queue_seg(24'sd512, 24'sd512, 24'sd512, 24'sd512);
        queue_seg(24'sd0, 24'sd256, 24'sd2560, 24'sd256);
        queue_seg(24'sd768, -24'sd512, 24'sd768, 24'sd512);
        queue_seg(-24'sd1024, -24'sd2048, 24'sd1024, 24'sd2048);
        queue_seg(24'sh7FFFFF, -24'sh800000, -24'sh800000, 24'sh7FFFFF);
        queue_cast(16'd0, 24'sd0, 24'sd0, 16'd0);
        queue_cast(16'd16384, 24'sd0, -24'sd1024, 16'd16384);
        queue_cast(16'd32768, 24'sd2560, 24'sd0, 16'd0);
        queue_cast(16'd49152, 24'sd1280, 24'sd0, 16'd65535);
        queue_cast(16'd65535, 24'sh7FFFFF, -24'sh800000, 16'd32768);
        queue_clear(2'd3);
        queue_cast(16'd8192, 24'sd0, 24'sd0, 16'd8192);
        queue_clear(CMD_CLEAR);
        queue_cast(16'd0, 24'sd0, 24'sd0, 16'd0);
        for (int i = 0; i < 34; i++)
            queue_seg(24'sd1024 + 24'(i * 16), -24'sd4096, 24'sd1024 + 24'(i * 16), 24'sd4096);
        queue_cast(16'd0, 24'sd0, 24'sd0, 16'd0);
        drain();

        write_view(16'd65535);
        queue_cast(16'd32768, 24'sd8192, 24'sd0, 16'd0);
        queue_clear(CMD_CLEAR);
        random_scene(30);
        drain();

        write_view(16'd0);
        send_idle_pct = 57;
        recv_idle_pct = 20;
        queue_cast(16'd0, 24'sd0, 24'sd0, 16'd0);
        queue_clear(CMD_CLEAR);
        random_scene(30);
        drain();

        write_view(16'($urandom_range(65535, 8192)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_scene(30);
        drain();

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
